/* rtl/msp_pkg.sv */
// shared constants, types and tables for the mollweide segment projector
`timescale 1ns / 1ps

package msp_pkg;

    // sizing
    localparam int MAX_SEGMENTS     = 65536;
    localparam int NEWTON_MAX_STEPS = 20;
    localparam int CORDIC_STEPS     = 30;
    localparam int W_KEPT   = $clog2(MAX_SEGMENTS + 1);
    localparam int W_STEP   = $clog2(NEWTON_MAX_STEPS + 1);
    localparam int W_CSTEP  = $clog2(CORDIC_STEPS);
    localparam int W_IN     = 18;
    localparam int W_OUT    = 19;
    localparam int W_IDX    = 16;
    localparam int W_V      = 36;
    localparam int W_MB     = 33;
    localparam int W_P      = W_V + W_MB + 1;
    localparam int W_MCNT   = $clog2(W_MB);
    localparam int W_SQN    = 61;
    localparam int W_ROOT   = 31;
    localparam int W_SCNT   = $clog2(W_ROOT);
    localparam int W_Q      = 33;
    localparam int W_DEN    = 35;
    localparam int W_DCNT   = $clog2(W_Q);
    localparam int W_SUMSQ  = 43;
    localparam int W_IN_BUS  = 112;
    localparam int W_OUT_BUS = 136;

    typedef logic signed [W_V-1:0]   t_ang;
    typedef logic signed [W_OUT-1:0] t_q16;

    // q30 constants, plus q16, q32 and q60 constants and the step cap
    localparam t_ang ONE_Q30         = 36'sd1073741824;
    localparam t_ang PI_Q30          = 36'sd3373259426;
    localparam t_ang HALF_PI_Q30     = 36'sd1686629713;
    localparam t_ang GAIN_INV_Q30    = 36'sd652032874;
    localparam t_ang TWO_OVER_PI_Q30 = 36'sd683565276;
    localparam t_ang TOL_Q30         = 36'sd1074;
    localparam t_q16 DEPTH_Q16       = 19'sd7;
    localparam logic [W_SUMSQ-1:0] LEN_LIMIT_Q32 = 43'd20787641713;
    localparam logic [W_SQN-1:0]   ONE_SQ_Q60    = 61'h1000_0000_0000_0000;
    localparam logic [W_Q-1:0]     STEP_CAP      = 33'h1_0000_0000;

    // register indexes and face codes
    localparam logic CFG_PROJ_EN = 1'b0;
    localparam logic CFG_FACE    = 1'b1;
    localparam logic [3:0] FACE_MIRROR_A = 4'd2;
    localparam logic [3:0] FACE_MIRROR_B = 4'd10;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ZSQ, ST_SQRT, ST_LAT, ST_LON, ST_TGT, ST_RES, ST_CHK,
        ST_DIV, ST_FIN, ST_HM1, ST_HM2, ST_DY, ST_DZ, ST_EMIT
    } t_state;

    // arctangent of 2^-k in q30
    function automatic logic [29:0] atan_entry(input logic [W_CSTEP-1:0] k);
        logic [29:0] v;
        unique case (k)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000008;
            5'd28: v = 30'h00000004;
            5'd29: v = 30'h00000002;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

    // q30 to q16, round half up
    function automatic t_q16 to_q16(input t_ang v);
        t_ang r;
        r = v + 36'sd8192;
        return r[W_OUT+13:14];
    endfunction

endpackage

/* rtl/msp_mul.sv */
// shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module msp_mul import msp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [W_V-1:0] i_a,
    input  logic signed [W_MB-1:0] i_b,
    output logic                  o_done,
    output logic signed [W_P-1:0] o_p
);

    logic              r_busy, r_done;
    logic [W_MCNT-1:0] r_cnt;
    logic [W_V-1:0]    r_am;
    logic [W_V:0]      r_hi;
    logic [W_MB-1:0]   r_lo;
    logic              r_neg;
    logic [W_V:0]      sum;
    logic [W_P-1:0]    prod;

    // one partial product per cycle
    assign sum  = r_hi + (r_lo[0] ? {1'b0, r_am} : '0);
    assign prod = {r_hi, r_lo};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == W_MCNT'(W_MB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and product shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_am  <= W_V'(i_a[W_V-1] ? -i_a : i_a);
            r_lo  <= W_MB'(i_b[W_MB-1] ? -i_b : i_b);
            r_hi  <= '0;
            r_neg <= i_a[W_V-1] ^ i_b[W_MB-1];
        end else if (r_busy) begin
            r_hi <= {1'b0, sum[W_V:1]};
            r_lo <= {sum[0], r_lo[W_MB-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_neg ? -$signed(prod) : $signed(prod);

endmodule

/* rtl/msp_sqrt.sv */
// integer square root, one root bit per cycle
`timescale 1ns / 1ps

module msp_sqrt import msp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [W_SQN-1:0]  i_n,
    output logic              o_done,
    output logic [W_ROOT-1:0] o_root
);

    logic              r_busy, r_done;
    logic [W_SCNT-1:0] r_cnt;
    logic [W_SQN-1:0]  r_n, r_bit;
    logic [W_SQN:0]    r_res;
    logic [W_SQN:0]    trial;

    assign trial = r_res + {1'b0, r_bit};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == W_SCNT'(W_ROOT - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // digit recurrence
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_res <= '0;
            r_bit <= {1'b1, {(W_SQN-1){1'b0}}};
        end else if (r_busy) begin
            if ({1'b0, r_n} >= trial) begin
                r_n   <= r_n - trial[W_SQN-1:0];
                r_res <= (r_res >> 1) + {1'b0, r_bit};
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[W_ROOT-1:0];

endmodule

/* rtl/msp_div.sv */
// newton step divider, one quotient bit per cycle, capped quotient
`timescale 1ns / 1ps

module msp_div import msp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W_V-1:0]   i_num,
    input  logic [W_DEN-1:0] i_den,
    output logic             o_done,
    output logic [W_Q-1:0]   o_q
);

    logic              r_busy, r_done, r_over;
    logic [W_DCNT-1:0] r_cnt;
    logic [W_DEN:0]    r_rem;
    logic [W_DEN-1:0]  r_den;
    logic [W_Q-1:0]    r_nb, r_q;
    logic [W_DEN:0]    shifted;
    logic              fits;

    // numerator is num * 2^30; top part loaded at start, rest brought down
    assign shifted = {r_rem[W_DEN-1:0], r_nb[W_Q-1]};
    assign fits    = shifted >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == W_DCNT'(W_Q - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_over <= (W_DEN + 1)'(i_num >> 3) >= {1'b0, i_den};
            r_rem  <= (W_DEN + 1)'(i_num >> 3);
            r_nb   <= {i_num[2:0], 30'd0};
            r_q    <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? shifted - {1'b0, r_den} : shifted;
            r_q   <= {r_q[W_Q-2:0], fits};
            r_nb  <= {r_nb[W_Q-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_q    = (r_over || r_q > STEP_CAP) ? STEP_CAP : r_q;

endmodule

/* rtl/msp_cordic.sv */
// iterative cordic, vectoring (atan2) or rotation (sin/cos), one step per cycle
`timescale 1ns / 1ps

module msp_cordic import msp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_rot,
    input  t_ang i_x,
    input  t_ang i_y,
    input  t_ang i_ang,
    output logic o_done,
    output t_ang o_ang,
    output t_ang o_cos,
    output t_ang o_sin
);

    logic               r_busy, r_done;
    logic [W_CSTEP-1:0] r_k;
    t_ang               r_x, r_y, r_z;
    logic               r_rot, r_flip, r_zero;
    t_ang               x0, y0, z0;
    logic               flip0;
    t_ang               sx, sy, tab;
    logic               plus;

    // quadrant pre-rotation or angle folding
    always_comb begin
        x0    = i_x;
        y0    = i_y;
        z0    = '0;
        flip0 = 1'b0;
        if (i_rot) begin
            x0 = GAIN_INV_Q30;
            y0 = '0;
            z0 = i_ang;
            if (i_ang > HALF_PI_Q30) begin
                z0    = i_ang - PI_Q30;
                flip0 = 1'b1;
            end else if (i_ang < -HALF_PI_Q30) begin
                z0    = i_ang + PI_Q30;
                flip0 = 1'b1;
            end
        end else if (i_x < 0) begin
            if (i_y >= 0) begin
                x0 = i_y;
                y0 = -i_x;
                z0 = HALF_PI_Q30;
            end else begin
                x0 = -i_y;
                y0 = i_x;
                z0 = -HALF_PI_Q30;
            end
        end
    end

    // micro-rotation direction
    assign sx   = r_x >>> r_k;
    assign sy   = r_y >>> r_k;
    assign tab  = W_V'(atan_entry(r_k));
    assign plus = r_rot ? !r_z[W_V-1] : (r_y <= 0);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 1'b1;
                if (r_k == W_CSTEP'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // vector and angle registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= x0;
            r_y    <= y0;
            r_z    <= z0;
            r_rot  <= i_rot;
            r_flip <= flip0;
            r_zero <= !i_rot && i_x == 0 && i_y == 0;
        end else if (r_busy) begin
            if (plus) begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - tab;
            end else begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + tab;
            end
        end
    end

    assign o_done = r_done;
    assign o_ang  = r_zero ? '0 : r_z;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

/* rtl/mollweide_segment_projector.sv */
// mollweide segment projector top level: sequencer, newton loop, output register
//
//  channel   | dir | beat
//  s_axis    | in  | a_x, a_y, a_z, b_x, b_y, b_z (18-bit signed q2.16 each)
//  m_axis    | out | out_a_x .. out_b_z (19-bit q3.16 each), segment_index
//  i_cfg_*   | in  | index 0 projection_enable, index 1 face_number
//
// each newton step runs a cordic pass and a divide, up to 20 per endpoint;
// a pass-through segment goes straight from idle to emit.
// reset sets up the sequencer, control registers and kept count; no clearing pass.
// a new beat is taken only when idle; a finished beat waits in the output
// register while the next segment is accepted and worked on.
`timescale 1ns / 1ps

module mollweide_segment_projector import msp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, zero pad
    input  logic [W_IN_BUS-1:0]  s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z, segment_index, zero pad
    output logic [W_OUT_BUS-1:0] m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [3:0]           i_cfg_data
);

    t_state              r_state, n_state;
    logic                r_first;
    logic                r_ep, r_proj;
    logic                r_proj_en;
    logic [3:0]          r_face;
    logic [W_KEPT-1:0]   r_kept;
    logic                r_m_valid;
    logic [W_OUT_BUS-1:0] r_tdata;
    t_q16                r_ov [6];
    t_ang                r_lat, r_lon, r_tgt, r_ang, r_res, r_cr, r_h;
    logic [W_STEP-1:0]   r_step;
    logic [W_SUMSQ-1:0]  r_sq;

    logic                accept, out_free;
    logic                mul_start, sqrt_start, cor_start, div_start, cor_rot;
    logic                mul_done, sqrt_done, cor_done, div_done;
    t_ang                mul_a, cor_x, cor_y, cor_ang;
    logic signed [W_MB-1:0] mul_b;
    logic signed [W_P-1:0]  mul_p;
    logic [W_ROOT-1:0]   root;
    t_ang                cor_a_out, cor_c, cor_s;
    logic [W_Q-1:0]      quot;
    logic signed [W_IN-1:0] px, py, pzc;
    t_q16                pz;
    logic signed [31:0]  z30;
    logic                pole_n, pole_s, stop;
    t_ang                slope, res_abs, ang_step, hor, hor_m;
    logic signed [W_OUT:0] dy, dz;
    logic [W_SUMSQ-1:0]  sumsq;
    logic                keep;
    logic [W_IDX-1:0]    idx;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_tdata;

    // current endpoint, clamped z in q30
    assign px  = r_ep ? r_ov[3][W_IN-1:0] : r_ov[0][W_IN-1:0];
    assign py  = r_ep ? r_ov[4][W_IN-1:0] : r_ov[1][W_IN-1:0];
    assign pz  = r_ep ? r_ov[5] : r_ov[2];
    assign pzc = (pz > 19'sd65536) ? 18'sd65536 :
                 (pz < -19'sd65536) ? -18'sd65536 : pz[W_IN-1:0];
    assign z30 = $signed({pzc, 14'd0});

    // pole and newton stop tests
    assign pole_n   = ((r_lat - HALF_PI_Q30) < TOL_Q30) && ((r_lat - HALF_PI_Q30) > -TOL_Q30);
    assign pole_s   = ((r_lat + HALF_PI_Q30) < TOL_Q30) && ((r_lat + HALF_PI_Q30) > -TOL_Q30);
    assign slope    = (ONE_Q30 + r_cr) <<< 1;
    assign res_abs  = r_res[W_V-1] ? -r_res : r_res;
    assign stop     = (res_abs < TOL_Q30) || (r_step == W_STEP'(NEWTON_MAX_STEPS))
                      || (slope <= 0);
    assign ang_step = (r_res > 0) ? r_ang - W_V'(quot) : r_ang + W_V'(quot);

    // horizontal coordinate with mirroring
    assign hor   = mul_p[W_V+29:30];
    assign hor_m = ((r_face == FACE_MIRROR_A || r_face == FACE_MIRROR_B) && hor > 0)
                   ? -hor : hor;

    // length test
    assign dy    = r_ov[1] - r_ov[4];
    assign dz    = r_ov[2] - r_ov[5];
    assign sumsq = r_sq + mul_p[W_SUMSQ-1:0];
    assign keep  = sumsq < LEN_LIMIT_Q32;
    assign idx   = (32'(r_kept) > 32'd65535) ? 16'hFFFF : W_IDX'(r_kept);

    // shared arithmetic units
    msp_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_p(mul_p)
    );

    msp_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sqrt_start),
        .i_n(ONE_SQ_Q60 - mul_p[W_SQN-1:0]), .o_done(sqrt_done), .o_root(root)
    );

    msp_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start), .i_rot(cor_rot),
        .i_x(cor_x), .i_y(cor_y), .i_ang(cor_ang),
        .o_done(cor_done), .o_ang(cor_a_out), .o_cos(cor_c), .o_sin(cor_s)
    );

    msp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(res_abs), .i_den(slope[W_DEN-1:0]), .o_done(div_done), .o_q(quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = r_proj_en ? ST_ZSQ : ST_EMIT;
            ST_ZSQ:  if (mul_done) n_state = ST_SQRT;
            ST_SQRT: if (sqrt_done) n_state = ST_LAT;
            ST_LAT:  if (cor_done) n_state = ST_LON;
            ST_LON:  if (cor_done) n_state = ST_TGT;
            ST_TGT:  if (mul_done) n_state = (pole_n || pole_s) ? ST_FIN : ST_RES;
            ST_RES:  if (cor_done) n_state = ST_CHK;
            ST_CHK:  n_state = stop ? ST_FIN : ST_DIV;
            ST_DIV:  if (div_done) n_state = ST_RES;
            ST_FIN:  if (cor_done) n_state = ST_HM1;
            ST_HM1:  if (mul_done) n_state = ST_HM2;
            ST_HM2:  if (mul_done) n_state = r_ep ? ST_DY : ST_ZSQ;
            ST_DY:   if (mul_done) n_state = ST_DZ;
            ST_DZ:   if (mul_done) n_state = keep ? ST_EMIT : ST_IDLE;
            ST_EMIT: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // unit starts and operands
    always_comb begin
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        cor_start  = 1'b0;
        div_start  = 1'b0;
        cor_rot    = 1'b1;
        mul_a      = '0;
        mul_b      = '0;
        cor_x      = '0;
        cor_y      = '0;
        cor_ang    = r_ang;
        unique case (r_state)
            ST_ZSQ: begin
                mul_start = r_first;
                mul_a     = W_V'(z30);
                mul_b     = W_MB'(z30);
            end
            ST_SQRT: sqrt_start = r_first;
            ST_LAT: begin
                cor_start = r_first;
                cor_rot   = 1'b0;
                cor_x     = W_V'(root);
                cor_y     = W_V'(z30);
            end
            ST_LON: begin
                cor_start = r_first;
                cor_rot   = 1'b0;
                cor_x     = W_V'($signed({px, 14'd0}));
                cor_y     = W_V'($signed({py, 14'd0}));
            end
            ST_TGT: begin
                mul_start = r_first;
                mul_a     = PI_Q30;
                mul_b     = W_MB'(z30);
            end
            ST_RES: begin
                cor_start = r_first;
                cor_ang   = r_ang <<< 1;
            end
            ST_DIV: div_start = r_first;
            ST_FIN: cor_start = r_first;
            ST_HM1: begin
                mul_start = r_first;
                mul_a     = r_lon;
                mul_b     = W_MB'(cor_c);
            end
            ST_HM2: begin
                mul_start = r_first;
                mul_a     = r_h;
                mul_b     = W_MB'(TWO_OVER_PI_Q30);
            end
            ST_DY: begin
                mul_start = r_first;
                mul_a     = W_V'(dy);
                mul_b     = W_MB'(dy);
            end
            ST_DZ: begin
                mul_start = r_first;
                mul_a     = W_V'(dz);
                mul_b     = W_MB'(dz);
            end
            ST_IDLE, ST_CHK, ST_EMIT: ;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_first   <= 1'b1;
            r_ep      <= 1'b0;
            r_proj_en <= 1'b1;
            r_face    <= '0;
            r_kept    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= (n_state != r_state);
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PROJ_EN) r_proj_en <= i_cfg_data[0];
                if (i_cfg_idx == CFG_FACE)    r_face    <= i_cfg_data;
            end
            if (accept) r_ep <= 1'b0;
            else if (r_state == ST_HM2 && mul_done) r_ep <= 1'b1;
            if (m_axis_tready) r_m_valid <= 1'b0;
            if (r_state == ST_EMIT && out_free) begin
                r_m_valid <= 1'b1;
                if (32'(r_kept) < MAX_SEGMENTS) r_kept <= r_kept + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_proj  <= r_proj_en;
            r_ov[0] <= W_OUT'($signed(s_axis_tdata[17:0]));
            r_ov[1] <= W_OUT'($signed(s_axis_tdata[35:18]));
            r_ov[2] <= W_OUT'($signed(s_axis_tdata[53:36]));
            r_ov[3] <= W_OUT'($signed(s_axis_tdata[71:54]));
            r_ov[4] <= W_OUT'($signed(s_axis_tdata[89:72]));
            r_ov[5] <= W_OUT'($signed(s_axis_tdata[107:90]));
        end
        if (r_state == ST_LAT && cor_done) r_lat <= cor_a_out;
        if (r_state == ST_LON && cor_done) r_lon <= cor_a_out;
        if (r_state == ST_TGT && mul_done) begin
            r_tgt  <= mul_p[W_V+29:30];
            r_step <= '0;
            if (pole_n)      r_ang <= HALF_PI_Q30;
            else if (pole_s) r_ang <= -HALF_PI_Q30;
            else             r_ang <= r_lat >>> 1;
        end
        if (r_state == ST_RES && cor_done) begin
            r_res <= (r_ang <<< 1) + cor_s - r_tgt;
            r_cr  <= cor_c;
        end
        if (r_state == ST_DIV && div_done) begin
            r_step <= r_step + 1'b1;
            if (ang_step > HALF_PI_Q30)       r_ang <= HALF_PI_Q30;
            else if (ang_step < -HALF_PI_Q30) r_ang <= -HALF_PI_Q30;
            else                              r_ang <= ang_step;
        end
        if (r_state == ST_FIN && cor_done) begin
            if (r_ep) r_ov[5] <= to_q16(cor_s);
            else      r_ov[2] <= to_q16(cor_s);
        end
        if (r_state == ST_HM1 && mul_done) r_h <= mul_p[W_V+29:30];
        if (r_state == ST_HM2 && mul_done) begin
            if (r_ep) r_ov[4] <= to_q16(hor_m);
            else      r_ov[1] <= to_q16(hor_m);
        end
        if (r_state == ST_DY && mul_done) r_sq <= mul_p[W_SUMSQ-1:0];
        // output beat
        if (r_state == ST_EMIT && out_free) begin
            r_tdata <= {6'd0, idx, r_ov[5], r_ov[4], r_proj ? DEPTH_Q16 : r_ov[3],
                        r_ov[2], r_ov[1], r_proj ? DEPTH_Q16 : r_ov[0]};
        end
    end

    // kept count never passes its saturation point
    a_kept_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_kept) <= MAX_SEGMENTS)
        else $error("kept count overflow");

    // a projected segment always starts with the first endpoint
    a_proj_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_proj_en) |=> (r_state == ST_ZSQ && !r_ep))
        else $error("projection did not start on first endpoint");

    // newton loop never runs past its step budget
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_CHK) |-> r_step < W_STEP'(NEWTON_MAX_STEPS + 1))
        else $error("newton step count out of range");

    // auxiliary angle stays within the half turn
    a_ang_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHK || r_state == ST_FIN)
        |-> (r_ang <= HALF_PI_Q30 && r_ang >= -HALF_PI_Q30))
        else $error("auxiliary angle out of range");

    // leaving emit always presents a beat
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free) |=> m_axis_tvalid)
        else $error("emitted beat lost");

endmodule
